// ===== hdl/rhs_pkg.sv =====
// Shared types, constants and elaboration-time helpers of the rolling-hash substring search.
package rhs_pkg;

  localparam int HASH_W     = 30;
  localparam int POS_W      = 32;
  localparam int BYTE_W     = 8;
  localparam int MODE_W     = 2;
  localparam int LEN_W      = 7;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 64;
  localparam int PROD_W     = 2 * HASH_W;
  localparam int GRP_W      = 8;

  localparam int OUT_DEPTH  = 16;
  localparam int OUT_PTR_W  = 4;
  localparam int OUT_CNT_W  = 5;

  localparam logic [63:0] HASH_BASE  = 64'd263;
  localparam logic [63:0] HASH_PRIME = 64'd1000000007;

  // floor(2^60 / prime), Barrett constant for products below prime^2
  localparam logic [30:0] BARRETT_MU = 31'((64'd1 << PROD_W) / HASH_PRIME);

  // register index, taken from paddr[2]
  localparam logic REG_PATTERN_LENGTH = 1'b0;

  typedef enum logic [MODE_W-1:0] {
    MODE_RESTART = 2'd0,
    MODE_PATTERN = 2'd1,
    MODE_TEXT    = 2'd2
  } mode_t;

  typedef logic [HASH_W-1:0] hash_t;

  typedef struct packed {
    logic pat_shift;
    logic win_shift;
    logic in_use;
  } cell_ctrl_t;

  typedef struct packed {
    logic             v;
    logic             qual;
    logic [POS_W-1:0] pos;
  } trk_t;

  function automatic hash_t pow_mod(input logic [63:0] base, input logic [31:0] e);
    logic [63:0] r;
    logic [63:0] b;
    logic [31:0] k_e;
    r   = 64'd1;
    b   = base % HASH_PRIME;
    k_e = e;
    for (int i = 0; i < 32; i++) begin
      if (k_e[0]) begin
        r = (r * b) % HASH_PRIME;
      end
      b   = (b * b) % HASH_PRIME;
      k_e = k_e >> 1;
    end
    return HASH_W'(r);
  endfunction

  localparam hash_t HASH_BASE_INV = pow_mod(HASH_BASE, 32'(HASH_PRIME - 64'd2));

endpackage

// ===== hdl/rhs_cell.sv =====
// One window cell: a pattern byte, a text byte and their registered compare.
module rhs_cell (
  input  logic                         clk,
  input  rhs_pkg::cell_ctrl_t          ctrl_i,
  input  logic [rhs_pkg::BYTE_W-1:0]   pat_i,
  input  logic [rhs_pkg::BYTE_W-1:0]   win_i,
  output logic [rhs_pkg::BYTE_W-1:0]   pat_o,
  output logic [rhs_pkg::BYTE_W-1:0]   win_o,
  output logic                         eq_o
);

  logic [rhs_pkg::BYTE_W-1:0] pat_r;
  logic [rhs_pkg::BYTE_W-1:0] win_r;
  logic                       eq_r;
  logic                       eq_nxt;

  assign eq_nxt = (pat_r == win_r) || !ctrl_i.in_use;

  always_ff @(posedge clk) begin
    if (ctrl_i.pat_shift) begin
      pat_r <= pat_i;
    end
    if (ctrl_i.win_shift) begin
      win_r <= win_i;
    end
    eq_r <= eq_nxt;
  end

  assign pat_o = pat_r;
  assign win_o = win_r;
  assign eq_o  = eq_r;

endmodule

// ===== hdl/rhs_modmul.sv =====
// Five-stage modular multiplier, Barrett reduction by the hash prime, with a side tag.
module rhs_modmul #(
  parameter int TAG_W = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                valid_i,
  input  rhs_pkg::hash_t      a_i,
  input  rhs_pkg::hash_t      b_i,
  input  logic [TAG_W-1:0]    tag_i,
  output logic                valid_o,
  output rhs_pkg::hash_t      r_o,
  output logic [TAG_W-1:0]    tag_o
);

  localparam int PW = rhs_pkg::PROD_W;

  logic [4:0]          v_r;
  logic [TAG_W-1:0]    tag1_r, tag2_r, tag3_r, tag4_r, tag5_r;
  logic [PW-1:0]       x1_r, x2_r, x3_r;
  logic [PW-1:0]       x1_nxt;
  logic [61:0]         qm;
  logic [29:0]         q2_r;
  logic [PW-1:0]       qp3_r;
  logic [31:0]         r4_r;
  logic [31:0]         r4_nxt;
  logic [31:0]         p1, p2;
  rhs_pkg::hash_t      r5_r;
  rhs_pkg::hash_t      r5_nxt;

  assign x1_nxt = PW'(a_i) * PW'(b_i);
  assign qm     = 62'(x1_r[PW-1:29]) * 62'(rhs_pkg::BARRETT_MU);
  assign r4_nxt = 32'(x3_r - qp3_r);
  assign p1     = 32'(rhs_pkg::HASH_PRIME);
  assign p2     = 32'(rhs_pkg::HASH_PRIME << 1);

  always_comb begin
    priority if (r4_r >= p2) begin
      r5_nxt = rhs_pkg::HASH_W'(r4_r - p2);
    end else if (r4_r >= p1) begin
      r5_nxt = rhs_pkg::HASH_W'(r4_r - p1);
    end else begin
      r5_nxt = rhs_pkg::HASH_W'(r4_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[3:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    x1_r   <= x1_nxt;
    tag1_r <= tag_i;
    q2_r   <= qm[60:31];
    x2_r   <= x1_r;
    tag2_r <= tag1_r;
    qp3_r  <= PW'(q2_r) * PW'(rhs_pkg::HASH_PRIME);
    x3_r   <= x2_r;
    tag3_r <= tag2_r;
    r4_r   <= r4_nxt;
    tag4_r <= tag3_r;
    r5_r   <= r5_nxt;
    tag5_r <= tag4_r;
  end

  assign valid_o = v_r[4];
  assign r_o     = r5_r;
  assign tag_o   = tag5_r;

endmodule

// ===== hdl/rolling_hash_substring_search_top.sv =====
// Top level of the rolling-hash substring search: cell chain, hash pipelines, result queue.
//
//  port group  | dir | contents
//  in_*        | in  | tuser[1:0] mode, tdata[7:0] data byte
//  out_*       | out | tdata[31:0] match position, [61:32] window hash
//  cfg_*       | in  | APB, register 0 at byte address 0: pattern length
//
// One request per cycle in any mode while in_tready is high; results leave via the result queue.
// The window compare runs in the cell chain, the hash in two five-stage multipliers.
// in_tready drops only while 16 text requests sit in the pipeline and the result queue.
// Reset clears control state only; stale window and pattern cells are never compared.
module rolling_hash_substring_search_top #(
  parameter int MAX_PATTERN = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [rhs_pkg::IN_DATA_W-1:0]     in_tdata,   // [7:0] data_byte
  input  logic [rhs_pkg::MODE_W-1:0]        in_tuser,   // [1:0] mode
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rhs_pkg::OUT_DATA_W-1:0]    out_tdata,  // [31:0] match_position, [61:32] window_hash
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [rhs_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [rhs_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [rhs_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  localparam int FILLW = $clog2(MAX_PATTERN + 1);
  localparam int IDXW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int NGRP  = (MAX_PATTERN + rhs_pkg::GRP_W - 1) / rhs_pkg::GRP_W;
  localparam int BW    = rhs_pkg::BYTE_W;
  localparam int PSW   = rhs_pkg::POS_W;
  localparam int HW    = rhs_pkg::HASH_W;

  // configuration
  logic [rhs_pkg::LEN_W-1:0] plen_r;
  logic [FILLW-1:0]          n_r;
  logic [FILLW-1:0]          n_nxt;
  logic                      cfg_wr;

  // control state
  logic [FILLW-1:0]          pfill_r, wfill_r, wfill_inc;
  logic [PSW-1:0]            pos_r;
  rhs_pkg::hash_t            g_r;
  logic [rhs_pkg::OUT_CNT_W-1:0] cnt_r;

  // request decode
  rhs_pkg::mode_t            mode;
  logic [BW-1:0]             byte_in;
  logic                      acc, restart, pat_take, text_acc;

  // cell chain
  logic [BW-1:0]             pat_chain [MAX_PATTERN+1];
  logic [BW-1:0]             win_chain [MAX_PATTERN+1];
  logic [MAX_PATTERN-1:0]    eq;
  logic [NGRP*rhs_pkg::GRP_W-1:0] eq_pad;
  logic [NGRP-1:0]           grp_r;
  rhs_pkg::hash_t            pow_tab [MAX_PATTERN];
  rhs_pkg::hash_t            inv_tab [MAX_PATTERN];

  // tracking pipeline
  rhs_pkg::trk_t             trk0_r, trk1_r, trk2_r, m3_r, m4_r, m5_r;
  rhs_pkg::trk_t             trk0_nxt;
  logic                      hit, drop;

  // multipliers
  logic                      mm1_v, mm1_tag;
  rhs_pkg::hash_t            mm1_r;
  logic                      mm2_v;
  rhs_pkg::hash_t            mm2_r;
  logic [PSW-1:0]            mm2_pos;
  logic [HW:0]               g_sum;
  rhs_pkg::hash_t            g_nxt;

  // result queue
  logic [PSW-1:0]            q_pos  [rhs_pkg::OUT_DEPTH];
  rhs_pkg::hash_t            q_hash [rhs_pkg::OUT_DEPTH];
  logic [rhs_pkg::OUT_PTR_W-1:0] wp_r, rp_r;
  logic [rhs_pkg::OUT_CNT_W-1:0] qn_r;
  logic                      pop;

  // ---------------------------------------------------------------- config
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == rhs_pkg::REG_PATTERN_LENGTH);
  assign cfg_prdata = (cfg_paddr[2] == rhs_pkg::REG_PATTERN_LENGTH)
                      ? rhs_pkg::CFG_DATA_W'(plen_r) : '0;

  always_comb begin
    priority if (cfg_pwdata[rhs_pkg::LEN_W-1:0] == '0) begin
      n_nxt = FILLW'(1);
    end else if (int'(cfg_pwdata[rhs_pkg::LEN_W-1:0]) > MAX_PATTERN) begin
      n_nxt = FILLW'(MAX_PATTERN);
    end else begin
      n_nxt = FILLW'(cfg_pwdata[rhs_pkg::LEN_W-1:0]);
    end
  end

  // ---------------------------------------------------------------- decode
  assign mode     = rhs_pkg::mode_t'(in_tuser);
  assign byte_in  = in_tdata[BW-1:0];
  assign acc      = in_tvalid && in_tready;
  assign in_tready = (cnt_r != rhs_pkg::OUT_CNT_W'(rhs_pkg::OUT_DEPTH));

  always_comb begin
    restart  = 1'b0;
    pat_take = 1'b0;
    text_acc = 1'b0;
    unique case (mode)
      rhs_pkg::MODE_RESTART: restart  = acc;
      rhs_pkg::MODE_PATTERN: pat_take = acc && (pfill_r < n_r);
      rhs_pkg::MODE_TEXT:    text_acc = acc;
      default: ;
    endcase
  end

  assign wfill_inc = (wfill_r == FILLW'(MAX_PATTERN)) ? wfill_r : wfill_r + FILLW'(1);

  always_comb begin
    trk0_nxt.v    = text_acc;
    trk0_nxt.qual = (wfill_inc >= n_r) && (pfill_r == n_r);
    trk0_nxt.pos  = pos_r + PSW'(1) - PSW'(n_r);
  end

  // ---------------------------------------------------------------- cells
  assign pat_chain[0] = byte_in;
  assign win_chain[0] = byte_in;

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    rhs_pkg::cell_ctrl_t ctrl;
    assign ctrl.pat_shift = pat_take;
    assign ctrl.win_shift = text_acc;
    assign ctrl.in_use    = (32'(j) < 32'(n_r));
    assign pow_tab[j] = rhs_pkg::pow_mod(rhs_pkg::HASH_BASE, 32'(j));
    assign inv_tab[j] = rhs_pkg::pow_mod(64'(rhs_pkg::HASH_BASE_INV), 32'(j));

    rhs_cell u_cell (
      .clk    (clk),
      .ctrl_i (ctrl),
      .pat_i  (pat_chain[j]),
      .win_i  (win_chain[j]),
      .pat_o  (pat_chain[j+1]),
      .win_o  (win_chain[j+1]),
      .eq_o   (eq[j])
    );
  end

  for (genvar k = 0; k < NGRP * rhs_pkg::GRP_W; k++) begin : g_pad
    if (k < MAX_PATTERN) begin : g_live
      assign eq_pad[k] = eq[k];
    end else begin : g_fill
      assign eq_pad[k] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NGRP; g++) begin
      grp_r[g] <= &eq_pad[g*rhs_pkg::GRP_W +: rhs_pkg::GRP_W];
    end
  end

  assign hit  = trk2_r.v && trk2_r.qual && (&grp_r);
  assign drop = trk2_r.v && !hit;

  // ---------------------------------------------------------------- pattern hash
  // running sum of b_i * 263^-i; the output scales it by 263^(L-1)
  rhs_modmul #(.TAG_W(1)) u_mm_pat (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (pat_take || restart),
    .a_i     (HW'(byte_in)),
    .b_i     (inv_tab[pfill_r[IDXW-1:0]]),
    .tag_i   (restart),
    .valid_o (mm1_v),
    .r_o     (mm1_r),
    .tag_o   (mm1_tag)
  );

  assign g_sum = (HW+1)'(g_r) + (HW+1)'(mm1_r);
  assign g_nxt = (g_sum >= (HW+1)'(rhs_pkg::HASH_PRIME))
                 ? HW'(g_sum - (HW+1)'(rhs_pkg::HASH_PRIME)) : HW'(g_sum);

  // ---------------------------------------------------------------- result hash
  rhs_modmul #(.TAG_W(PSW)) u_mm_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (m5_r.v),
    .a_i     (g_r),
    .b_i     (pow_tab[IDXW'(n_r - FILLW'(1))]),
    .tag_i   (m5_r.pos),
    .valid_o (mm2_v),
    .r_o     (mm2_r),
    .tag_o   (mm2_pos)
  );

  // ---------------------------------------------------------------- result queue
  assign out_tvalid = (qn_r != '0);
  assign pop        = out_tvalid && out_tready;
  assign out_tdata  = {{(rhs_pkg::OUT_DATA_W - PSW - HW){1'b0}}, q_hash[rp_r], q_pos[rp_r]};

  always_ff @(posedge clk) begin
    if (mm2_v) begin
      q_pos[wp_r]  <= mm2_pos;
      q_hash[wp_r] <= mm2_r;
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r  <= rhs_pkg::LEN_W'(1);
      n_r     <= FILLW'(1);
      pfill_r <= '0;
      wfill_r <= '0;
      pos_r   <= '0;
      g_r     <= '0;
      cnt_r   <= '0;
      trk0_r.v <= 1'b0;
      trk1_r.v <= 1'b0;
      trk2_r.v <= 1'b0;
      m3_r.v  <= 1'b0;
      m4_r.v  <= 1'b0;
      m5_r.v  <= 1'b0;
      wp_r    <= '0;
      rp_r    <= '0;
      qn_r    <= '0;
    end else begin
      if (cfg_wr) begin
        plen_r <= cfg_pwdata[rhs_pkg::LEN_W-1:0];
        n_r    <= n_nxt;
      end
      if (restart) begin
        pfill_r <= '0;
        wfill_r <= '0;
        pos_r   <= '0;
      end else begin
        if (pat_take) begin
          pfill_r <= pfill_r + FILLW'(1);
        end
        if (text_acc) begin
          wfill_r <= wfill_inc;
          pos_r   <= pos_r + PSW'(1);
        end
      end
      if (mm1_v) begin
        g_r <= mm1_tag ? '0 : g_nxt;
      end
      cnt_r <= cnt_r + rhs_pkg::OUT_CNT_W'(text_acc)
                     - rhs_pkg::OUT_CNT_W'(drop) - rhs_pkg::OUT_CNT_W'(pop);
      trk0_r.v <= trk0_nxt.v;
      trk1_r.v <= trk0_r.v;
      trk2_r.v <= trk1_r.v;
      m3_r.v   <= hit;
      m4_r.v   <= m3_r.v;
      m5_r.v   <= m4_r.v;
      if (mm2_v) begin
        wp_r <= wp_r + rhs_pkg::OUT_PTR_W'(1);
      end
      if (pop) begin
        rp_r <= rp_r + rhs_pkg::OUT_PTR_W'(1);
      end
      qn_r <= qn_r + rhs_pkg::OUT_CNT_W'(mm2_v) - rhs_pkg::OUT_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    trk0_r.qual <= trk0_nxt.qual;
    trk0_r.pos  <= trk0_nxt.pos;
    trk1_r.qual <= trk0_r.qual;
    trk1_r.pos  <= trk0_r.pos;
    trk2_r.qual <= trk1_r.qual;
    trk2_r.pos  <= trk1_r.pos;
    m3_r.qual   <= 1'b1;
    m3_r.pos    <= trk2_r.pos;
    m4_r.qual   <= m3_r.qual;
    m4_r.pos    <= m3_r.pos;
    m5_r.qual   <= m4_r.qual;
    m5_r.pos    <= m4_r.pos;
  end

  // ---------------------------------------------------------------- checks
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (qn_r == rhs_pkg::OUT_CNT_W'(rhs_pkg::OUT_DEPTH)) |-> !mm2_v || pop)
    else $error("result queue overflow");

  a_hash_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (64'(out_tdata[PSW+HW-1:PSW]) < rhs_pkg::HASH_PRIME))
    else $error("result hash not reduced");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    restart |=> (pfill_r == '0) && (wfill_r == '0) && (pos_r == '0))
    else $error("restart left state behind");

  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    text_acc |=> (pos_r == $past(pos_r) + PSW'(1)))
    else $error("text position did not advance");

  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    qn_r <= cnt_r)
    else $error("queue holds more than the credit count");

endmodule
